[rtl/core/bmmpq_pkg.sv]
// Shared types and codes for the bounded min/max priority queue.
package bmmpq_pkg;

    localparam int COUNT_W = 4;
    localparam int CAP_W   = 4;

    typedef logic [1:0] t_op;
    typedef logic [1:0] t_status;

    localparam t_op OP_INSERT     = 2'd0;
    localparam t_op OP_REMOVE_MIN = 2'd1;
    localparam t_op OP_REMOVE_MAX = 2'd2;
    localparam t_op OP_STATUS     = 2'd3;

    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_OVERFLOW  = 2'd1;
    localparam t_status ST_UNDERFLOW = 2'd2;

    localparam logic [CAP_W-1:0] CAPACITY_RESET = 4'd5;

    typedef struct packed {
        t_status status;
        logic    is_empty;
        logic    is_full;
    } t_flags;

endpackage

[rtl/core/bmmpq_store.sv]
// Sorted value array with count, plus next-state and result logic for one word.
module bmmpq_store #(
    parameter int DEPTH       = 8,
    parameter int VALUE_WIDTH = 32,
    localparam int CW         = $clog2(DEPTH + 1)
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_fire,
    input  bmmpq_pkg::t_op                  i_op,
    input  logic [VALUE_WIDTH-1:0]          i_value,
    input  logic [bmmpq_pkg::CAP_W-1:0]     i_capacity,
    output logic [VALUE_WIDTH-1:0]          o_moved,
    output bmmpq_pkg::t_flags               o_flags,
    output logic [CW-1:0]                   o_count,
    output logic [VALUE_WIDTH-1:0]          o_min,
    output logic [VALUE_WIDTH-1:0]          o_max
);

    localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int EXT_W = (CW > bmmpq_pkg::CAP_W) ? CW : bmmpq_pkg::CAP_W;

    logic [VALUE_WIDTH-1:0] r_cell [DEPTH];
    logic [VALUE_WIDTH-1:0] n_cell [DEPTH];
    logic [VALUE_WIDTH-1:0] r_max;
    logic [VALUE_WIDTH-1:0] n_max;
    logic [CW-1:0]          r_count;
    logic [CW-1:0]          n_count;
    logic [DEPTH-1:0]       lt;

    logic                   ins_ok;
    logic                   rem_min_ok;
    logic                   rem_max_ok;
    logic                   full_now;
    bmmpq_pkg::t_status     flag_status;
    logic [EXT_W-1:0]       cap_ext;
    logic [EXT_W-1:0]       count_ext;
    logic [EXT_W-1:0]       n_count_ext;
    logic [CW-1:0]          below_top;
    logic [VALUE_WIDTH-1:0] second_max;

    assign cap_ext     = EXT_W'(i_capacity);
    assign count_ext   = EXT_W'(r_count);
    assign n_count_ext = EXT_W'(n_count);
    assign full_now    = (count_ext >= cap_ext) || (r_count == CW'(DEPTH));

    always_comb begin
        ins_ok      = 1'b0;
        rem_min_ok  = 1'b0;
        rem_max_ok  = 1'b0;
        flag_status = bmmpq_pkg::ST_OK;
        unique case (i_op)
            bmmpq_pkg::OP_INSERT: begin
                ins_ok = !full_now;
                if (full_now) begin
                    flag_status = bmmpq_pkg::ST_OVERFLOW;
                end
            end
            bmmpq_pkg::OP_REMOVE_MIN: begin
                rem_min_ok = (r_count != '0);
                if (r_count == '0) begin
                    flag_status = bmmpq_pkg::ST_UNDERFLOW;
                end
            end
            bmmpq_pkg::OP_REMOVE_MAX: begin
                rem_max_ok = (r_count != '0);
                if (r_count == '0) begin
                    flag_status = bmmpq_pkg::ST_UNDERFLOW;
                end
            end
            default: begin
            end
        endcase
    end

    // Cells holding a value greater than the new one; monotonic over the held range.
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            lt[i] = (CW'(i) < r_count) && ($signed(i_value) < $signed(r_cell[i]));
        end
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic [VALUE_WIDTH-1:0] below;
            logic [VALUE_WIDTH-1:0] above;
            logic                   lt_below;

            if (g == 0) begin : g_first
                assign below    = '0;
                assign lt_below = 1'b0;
            end else begin : g_rest
                assign below    = r_cell[g-1];
                assign lt_below = lt[g-1];
            end

            if (g == DEPTH - 1) begin : g_top
                assign above = r_cell[g];
            end else begin : g_lower
                assign above = r_cell[g+1];
            end

            assign n_cell[g] =
                ins_ok ? (lt_below ? below :
                          ((lt[g] || (CW'(g) == r_count)) ? i_value : r_cell[g])) :
                rem_min_ok ? above : r_cell[g];

            always_ff @(posedge i_clk) begin
                if (i_fire) begin
                    r_cell[g] <= n_cell[g];
                end
            end
        end
    endgenerate

    // Next-largest value, read only when two or more are held.
    assign below_top  = r_count - CW'(2);
    assign second_max = (r_count >= CW'(2)) ? r_cell[below_top[IW-1:0]] : r_max;

    always_comb begin
        n_count = r_count;
        n_max   = r_max;
        if (ins_ok) begin
            n_count = r_count + CW'(1);
            if ((r_count == '0) || ($signed(i_value) >= $signed(r_max))) begin
                n_max = i_value;
            end
        end else if (rem_min_ok) begin
            n_count = r_count - CW'(1);
        end else if (rem_max_ok) begin
            n_count = r_count - CW'(1);
            n_max   = second_max;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_fire) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_max <= n_max;
        end
    end

    assign o_moved = ins_ok     ? i_value   :
                     rem_min_ok ? r_cell[0] :
                     rem_max_ok ? r_max     : '0;

    assign o_count = n_count;
    assign o_flags = '{status:   flag_status,
                       is_empty: (n_count == '0),
                       is_full:  (n_count_ext >= cap_ext) || (n_count == CW'(DEPTH))};
    assign o_min   = (n_count == '0) ? '1 : n_cell[0];
    assign o_max   = (n_count == '0) ? '1 : n_max;

endmodule

[rtl/core/bounded_min_max_priority_queue.sv]
// Top level of the bounded min/max priority queue: request and result registers.
// Path of a request word: request register, single-pass array update, result register.
// Throughput: one request word per cycle; only a stalled result side holds the input.
// Reset: synchronous, active low; empties the queue, drops words in flight and
// sets the capacity register to five.
module bounded_min_max_priority_queue #(
    parameter int DEPTH       = 8,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // request channel
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [1:0]                       i_opcode,
    input  logic signed [VALUE_WIDTH-1:0]    i_value_in,
    // result channel
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic signed [VALUE_WIDTH-1:0]    o_value_out,
    output logic [1:0]                       o_status,
    output logic [bmmpq_pkg::COUNT_W-1:0]    o_count,
    output logic                             o_is_empty,
    output logic                             o_is_full,
    output logic signed [VALUE_WIDTH-1:0]    o_min_value,
    output logic signed [VALUE_WIDTH-1:0]    o_max_value,
    // capacity register write channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [bmmpq_pkg::CAP_W-1:0]      i_cfg_data
);

    localparam int CW    = $clog2(DEPTH + 1);
    localparam int EXT_W = (CW > bmmpq_pkg::COUNT_W) ? CW : bmmpq_pkg::COUNT_W;

    // Capacity register; always ready. The user must write it only while idle; the block does not enforce this.
    logic [bmmpq_pkg::CAP_W-1:0] r_capacity;

    // Request register.
    logic                   r_in_valid;
    bmmpq_pkg::t_op         r_in_op;
    logic [VALUE_WIDTH-1:0] r_in_value;

    // Result register.
    logic                   r_out_valid;
    logic [VALUE_WIDTH-1:0] r_out_value;
    bmmpq_pkg::t_flags      r_out_flags;
    logic [CW-1:0]          r_out_count;
    logic [VALUE_WIDTH-1:0] r_out_min;
    logic [VALUE_WIDTH-1:0] r_out_max;

    // Combinational result of the word in the request register.
    logic [VALUE_WIDTH-1:0] res_moved;
    bmmpq_pkg::t_flags      res_flags;
    logic [CW-1:0]          res_count;
    logic [VALUE_WIDTH-1:0] res_min;
    logic [VALUE_WIDTH-1:0] res_max;

    logic                   out_adv;
    logic                   fire;
    logic                   in_adv;
    logic [EXT_W-1:0]       count_ext;

    // The result register frees up when empty or when its word is taken; the
    // request word executes (and commits to the array) exactly then.
    assign out_adv    = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && out_adv;
    assign in_adv     = !r_in_valid || fire;
    assign o_in_stall = !in_adv;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= bmmpq_pkg::CAPACITY_RESET;
        end else if (i_cfg_valid) begin
            r_capacity <= i_cfg_data;
        end
    end

    // Hold the request while the result side is blocked; advance otherwise.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_adv) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_adv && i_in_valid) begin
            r_in_op    <= i_opcode;
            r_in_value <= i_value_in;
        end
    end

    bmmpq_store #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (fire),
        .i_op       (r_in_op),
        .i_value    (r_in_value),
        .i_capacity (r_capacity),
        .o_moved    (res_moved),
        .o_flags    (res_flags),
        .o_count    (res_count),
        .o_min      (res_min),
        .o_max      (res_max)
    );

    // Capture the result word as the array commits; drop valid once it is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_value <= res_moved;
            r_out_flags <= res_flags;
            r_out_count <= res_count;
            r_out_min   <= res_min;
            r_out_max   <= res_max;
        end
    end

    // Count port is four bits wide whatever the depth.
    assign count_ext = EXT_W'(r_out_count);

    assign o_out_valid = r_out_valid;
    assign o_value_out = r_out_value;
    assign o_status    = r_out_flags.status;
    assign o_count     = count_ext[bmmpq_pkg::COUNT_W-1:0];
    assign o_is_empty  = r_out_flags.is_empty;
    assign o_is_full   = r_out_flags.is_full;
    assign o_min_value = r_out_min;
    assign o_max_value = r_out_max;

    // A rejected insert only happens against a full queue.
    a_overflow_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_flags.status == bmmpq_pkg::ST_OVERFLOW))
            |-> r_out_flags.is_full)
        else $error("overflow reported while queue not full");

    // A failed removal only happens against an empty queue.
    a_underflow_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_flags.status == bmmpq_pkg::ST_UNDERFLOW))
            |-> r_out_flags.is_empty)
        else $error("underflow reported while queue not empty");

    // The array stays sorted, so the reported minimum never exceeds the maximum.
    a_min_le_max : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_flags.is_empty)
            |-> ($signed(r_out_min) <= $signed(r_out_max)))
        else $error("minimum above maximum");

    // The held count never passes the array depth.
    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_count <= CW'(DEPTH)))
        else $error("count beyond depth");

endmodule

[verif/tb_bounded_min_max_priority_queue.sv]
// Self-checking testbench for the bounded min/max priority queue.
`timescale 1ns / 1ps

module tb_bounded_min_max_priority_queue;

    localparam int DEPTH          = 8;
    localparam int VALUE_WIDTH    = 32;
    localparam int HALF_PERIOD    = 6;
    localparam int RESET_CYCLES   = 9;
    localparam int IDLE_PCT       = 38;
    localparam int HOLDOFF_CYCLES = 90;
    localparam int SETTLE_CYCLES  = 4;      // margin for the block to settle
    localparam int CYCLE_LIMIT    = 200000;

    localparam logic signed [VALUE_WIDTH-1:0] MOST_NEGATIVE = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
    localparam logic signed [VALUE_WIDTH-1:0] MOST_POSITIVE = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam logic signed [VALUE_WIDTH-1:0] EMPTY_MARK    = '1;

    // One request word as offered on the input channel.
    typedef struct packed {
        bmmpq_pkg::t_op                op;
        logic signed [VALUE_WIDTH-1:0] value;
    } t_request;

    // One result word as it should leave the block.
    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0]   value_out;
        bmmpq_pkg::t_status              status;
        logic [bmmpq_pkg::COUNT_W-1:0]   count;
        logic                            is_empty;
        logic                            is_full;
        logic signed [VALUE_WIDTH-1:0]   min_value;
        logic signed [VALUE_WIDTH-1:0]   max_value;
    } t_reply;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_in_valid;
    logic                          o_in_stall;
    logic [1:0]                    i_opcode;
    logic signed [VALUE_WIDTH-1:0] i_value_in;
    logic                          o_out_valid;
    logic                          i_out_stall;
    logic signed [VALUE_WIDTH-1:0] o_value_out;
    logic [1:0]                    o_status;
    logic [bmmpq_pkg::COUNT_W-1:0] o_count;
    logic                          o_is_empty;
    logic                          o_is_full;
    logic signed [VALUE_WIDTH-1:0] o_min_value;
    logic signed [VALUE_WIDTH-1:0] o_max_value;
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    logic [bmmpq_pkg::CAP_W-1:0]   i_cfg_data;

    bounded_min_max_priority_queue #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_opcode    (i_opcode),
        .i_value_in  (i_value_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_value_out (o_value_out),
        .o_status    (o_status),
        .o_count     (o_count),
        .o_is_empty  (o_is_empty),
        .o_is_full   (o_is_full),
        .o_min_value (o_min_value),
        .o_max_value (o_max_value),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // Words still to be offered, and results still owed by the block, oldest first.
    t_request request_q[$];
    t_reply   reply_q[$];

    // Shadow of the queue contents: ascending order, only the first held_n cells live.
    logic signed [VALUE_WIDTH-1:0] held [DEPTH];
    int unsigned                   held_n;
    logic [bmmpq_pkg::CAP_W-1:0]   capacity_shadow;

    bit          released;       // reset has been let go
    bit          gaps_on;        // random idling on both channels
    bit          holdoff_req;    // ask the receiver for one long stall
    bit          holdoff_seen;
    int unsigned holdoff_left;
    bit          word_taken;     // the offered word went in at the last rising edge
    int unsigned cycle_count;
    int unsigned fault_count;
    int unsigned words_in;
    int unsigned replies_out;
    int unsigned overflow_seen;
    int unsigned underflow_seen;
    int unsigned cfg_writes;
    int unsigned in_stall_cycles;

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // Work out the result of one request and advance the shadow contents with it.
    function automatic t_reply apply_request(input bmmpq_pkg::t_op op,
                                             input logic signed [VALUE_WIDTH-1:0] v);
        t_reply      r;
        int unsigned room;
        int          k;
        room = (capacity_shadow > DEPTH) ? DEPTH : capacity_shadow;
        r = '0;
        r.status = bmmpq_pkg::ST_OK;
        case (op)
            bmmpq_pkg::OP_INSERT: begin
                if (held_n >= room) begin
                    r.status = bmmpq_pkg::ST_OVERFLOW;
                end else begin
                    // shift larger values up; an equal value lands after its twins
                    k = held_n;
                    while (k > 0 && v < held[k-1]) begin
                        held[k] = held[k-1];
                        k--;
                    end
                    held[k] = v;
                    held_n++;
                    r.value_out = v;
                end
            end
            bmmpq_pkg::OP_REMOVE_MIN, bmmpq_pkg::OP_REMOVE_MAX: begin
                if (held_n == 0) begin
                    r.status = bmmpq_pkg::ST_UNDERFLOW;
                end else if (op == bmmpq_pkg::OP_REMOVE_MIN) begin
                    r.value_out = held[0];
                    for (k = 1; k < held_n; k++)
                        held[k-1] = held[k];
                    held_n--;
                end else begin
                    r.value_out = held[held_n-1];
                    held_n--;
                end
            end
            default: begin
            end
        endcase
        r.count    = held_n[bmmpq_pkg::COUNT_W-1:0];
        r.is_empty = (held_n == 0);
        r.is_full  = (held_n >= room);
        r.min_value = (held_n == 0) ? EMPTY_MARK : held[0];
        r.max_value = (held_n == 0) ? EMPTY_MARK : held[held_n-1];
        return r;
    endfunction

    task automatic check_field(input string name, input logic signed [63:0] expv,
                               input logic signed [63:0] actv);
        if (actv !== expv) begin
            fault_count++;
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, expv, actv);
        end
    endtask

    // Sender: move on only once the offered word has gone in, otherwise hold it.
    always @(negedge i_clk) begin
        t_request w;
        if (word_taken || !i_in_valid) begin
            if (released && request_q.size() != 0 &&
                !(gaps_on && $urandom_range(0, 99) < IDLE_PCT)) begin
                w = request_q.pop_front();
                i_in_valid <= 1'b1;
                i_opcode   <= w.op;
                i_value_in <= w.value;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        word_taken = 1'b0;
    end

    // Accepted request words: predict their results in order of arrival.
    always @(posedge i_clk) begin
        t_reply r;
        if (i_rst_n && i_in_valid && o_in_stall)
            in_stall_cycles++;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            r = apply_request(i_opcode, i_value_in);
            reply_q.push_back(r);
            if (r.status == bmmpq_pkg::ST_OVERFLOW)
                overflow_seen++;
            if (r.status == bmmpq_pkg::ST_UNDERFLOW)
                underflow_seen++;
            words_in++;
            word_taken = 1'b1;
        end
    end

    // Long receiver hold-off, counted here so it runs independently of the sender.
    always @(negedge i_clk) begin
        if (holdoff_left != 0) begin
            holdoff_left <= holdoff_left - 1;
        end else if (holdoff_req && !holdoff_seen) begin
            holdoff_left <= HOLDOFF_CYCLES;
            holdoff_seen <= 1'b1;
        end
    end

    // Receiver: stall at random, or throughout the hold-off.
    always @(negedge i_clk) begin
        i_out_stall <= (holdoff_left != 0) || (gaps_on && $urandom_range(0, 99) < IDLE_PCT);
    end

    // Result words: compare against the oldest outstanding prediction.
    always @(posedge i_clk) begin
        t_reply e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            replies_out++;
            if (reply_q.size() == 0) begin
                fault_count++;
                $display("%0t ns: result word with nothing outstanding, expected none, got %0d",
                         $time, o_value_out);
            end else begin
                e = reply_q.pop_front();
                check_field("value_out", e.value_out, o_value_out);
                check_field("status",    e.status,    o_status);
                check_field("count",     e.count,     o_count);
                check_field("is_empty",  e.is_empty,  o_is_empty);
                check_field("is_full",   e.is_full,   o_is_full);
                check_field("min_value", e.min_value, o_min_value);
                check_field("max_value", e.max_value, o_max_value);
            end
        end
    end

    // Watchdog: drop the run if it hangs.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t ns: timed out with %0d results outstanding", $time, reply_q.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic logic signed [VALUE_WIDTH-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return MOST_NEGATIVE;
            1:       return MOST_POSITIVE;
            2:       return $urandom_range(0, 1) ? EMPTY_MARK : '0;
            3, 4, 5: return $signed($urandom_range(0, 15)) - 8;   // dense range for twins
            default: return $urandom;
        endcase
    endfunction

    task automatic push_word(input bmmpq_pkg::t_op op, input logic signed [VALUE_WIDTH-1:0] v);
        t_request w;
        w.op    = op;
        w.value = v;
        request_q.push_back(w);
    endtask

    // Random mix: insert_pct sets whether the phase tends to fill or drain the queue.
    task automatic push_random_words(input int n, input int insert_pct);
        int r;
        repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < insert_pct)
                push_word(bmmpq_pkg::OP_INSERT, pick_value());
            else if (r < insert_pct + 8)
                push_word(bmmpq_pkg::OP_STATUS, $urandom);
            else if ($urandom_range(0, 1))
                push_word(bmmpq_pkg::OP_REMOVE_MIN, $urandom);
            else
                push_word(bmmpq_pkg::OP_REMOVE_MAX, $urandom);
        end
    endtask

    // Wait until every word is in and every result is out, then settle.
    task automatic wait_drained();
        do @(posedge i_clk);
        while (request_q.size() != 0 || i_in_valid || reply_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Capacity writes happen only with the block idle.
    task automatic write_capacity(input logic [bmmpq_pkg::CAP_W-1:0] cap);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= cap;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        capacity_shadow = cap;
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [bmmpq_pkg::CAP_W-1:0] cap, input int n,
                             input int insert_pct);
        write_capacity(cap);
        push_random_words(n, insert_pct);
        wait_drained();
    endtask

    initial begin
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_opcode    = bmmpq_pkg::OP_STATUS;
        i_value_in  = '0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        held_n          = 0;
        capacity_shadow = bmmpq_pkg::CAPACITY_RESET;
        gaps_on         = 1'b1;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n  <= 1'b1;
        released = 1'b1;

        // Reset capacity: underflow on both ends, extremes, a duplicate, overflow when full.
        push_word(bmmpq_pkg::OP_REMOVE_MIN, '0);
        push_word(bmmpq_pkg::OP_REMOVE_MAX, '1);
        push_word(bmmpq_pkg::OP_INSERT, MOST_NEGATIVE);
        push_word(bmmpq_pkg::OP_INSERT, MOST_POSITIVE);
        push_word(bmmpq_pkg::OP_INSERT, EMPTY_MARK);
        push_word(bmmpq_pkg::OP_INSERT, '0);
        push_word(bmmpq_pkg::OP_INSERT, MOST_POSITIVE);
        push_word(bmmpq_pkg::OP_INSERT, 7);
        push_word(bmmpq_pkg::OP_REMOVE_MAX, '0);
        push_word(bmmpq_pkg::OP_REMOVE_MIN, '0);
        push_word(bmmpq_pkg::OP_INSERT, '0);
        wait_drained();

        // Capacity lowered below the count: contents stay, inserts bounce until drained.
        write_capacity(4'd2);
        push_word(bmmpq_pkg::OP_INSERT, 3);
        push_word(bmmpq_pkg::OP_STATUS, MOST_NEGATIVE);
        push_word(bmmpq_pkg::OP_REMOVE_MIN, '0);
        push_word(bmmpq_pkg::OP_REMOVE_MAX, '0);
        push_word(bmmpq_pkg::OP_INSERT, 5);
        push_word(bmmpq_pkg::OP_REMOVE_MIN, '0);
        push_word(bmmpq_pkg::OP_INSERT, 5);
        wait_drained();

        // Zero capacity: always full, every insert bounces.
        write_capacity(4'd0);
        push_word(bmmpq_pkg::OP_INSERT, 9);
        push_word(bmmpq_pkg::OP_REMOVE_MAX, '0);
        push_word(bmmpq_pkg::OP_REMOVE_MIN, '0);
        push_word(bmmpq_pkg::OP_REMOVE_MIN, '0);
        push_word(bmmpq_pkg::OP_STATUS, MOST_POSITIVE);
        wait_drained();

        // Random phases across the capacity range, top value saturating at the depth.
        run_phase(4'd15, 110, 65);
        run_phase(4'd8,  110, 35);
        run_phase(4'd1,   80, 50);
        run_phase(4'd3,  100, 60);
        run_phase(4'd0,   30, 50);

        // Block the receiver for a long stretch while words keep coming.
        write_capacity(4'd8);
        holdoff_req = 1'b1;
        push_random_words(150, 60);
        wait_drained();

        // No idling on either side.
        gaps_on = 1'b0;
        run_phase(4'd5, 110, 50);
        gaps_on = 1'b1;

        run_phase(4'd4, 110, 40);
        repeat (2 * SETTLE_CYCLES) @(posedge i_clk);

        $display("Covered %0d request words and %0d result words over %0d capacity writes,",
                 words_in, replies_out, cfg_writes);
        $display("with %0d overflows, %0d underflows and %0d cycles of input stall.",
                 overflow_seen, underflow_seen, in_stall_cycles);
        if (fault_count == 0 && reply_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
